// ----- hdl/hcb_pkg.sv -----
// Shared types and constants for the Huffman code builder.
// No dependencies; every other file imports this package.
package hcb_pkg;

  localparam int MAX_LEAVES = 32;
  localparam int NODE_SLOTS = 64;
  localparam int NODE_W     = 6;
  localparam int WEIGHT_W   = 16;
  localparam int SUM_W      = 21;
  localparam int CODE_W     = 31;
  localparam int LEN_W      = 5;

  // Input beat: one leaf weight
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                last_leaf;
  } leaf_beat_t;

  // Output beat: one code per leaf
  typedef struct packed {
    logic [4:0]        leaf_index;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              last_code;
    logic              overflowed;
  } code_beat_t;

  // One node record in the tree store; parent 0 means none
  typedef struct packed {
    logic              right;
    logic [NODE_W-1:0] parent;
    logic [SUM_W-1:0]  weight;
  } node_word_t;

  // Stream of node records into the minimum scan unit
  typedef struct packed {
    logic              clear;
    logic              valid;
    logic [NODE_W-1:0] idx;
    logic [SUM_W-1:0]  weight;
    logic              orphan;
  } scan_beat_t;

  // Two lightest parentless nodes found so far
  typedef struct packed {
    logic [NODE_W-1:0] a_idx;
    logic [SUM_W-1:0]  a_weight;
    logic [NODE_W-1:0] b_idx;
    logic [SUM_W-1:0]  b_weight;
  } scan_pick_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WR_NEW,
    S_WR_LO,
    S_WR_HI,
    S_WALK_START,
    S_WALK,
    S_OUT
  } hcb_state_t;

endpackage

// ----- hdl/hcb_node_ram.sv -----
// Node store: one write port, one read port with registered read data.
// Depends on hcb_pkg.
module hcb_node_ram
  import hcb_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [NODE_W-1:0] waddr,
  input  node_word_t        wdata,
  input  logic [NODE_W-1:0] raddr,
  output node_word_t        rdata
);

  node_word_t mem [NODE_SLOTS];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/hcb_min_scan.sv -----
// Shared compare unit: keeps the two lightest parentless nodes of a scan.
// Ties keep the earlier (lower) index. Depends on hcb_pkg.
module hcb_min_scan
  import hcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  scan_beat_t beat,
  output scan_pick_t pick
);

  logic a_ok, b_ok;

  // Update the pair on each streamed node without a parent
  always_ff @(posedge clk) begin
    if (rst || beat.clear) begin
      a_ok <= 1'b0;
      b_ok <= 1'b0;
    end else if (beat.valid && beat.orphan) begin
      if (!a_ok || beat.weight < pick.a_weight) begin
        pick.b_idx    <= pick.a_idx;
        pick.b_weight <= pick.a_weight;
        b_ok          <= a_ok;
        pick.a_idx    <= beat.idx;
        pick.a_weight <= beat.weight;
        a_ok          <= 1'b1;
      end else if (!b_ok || beat.weight < pick.b_weight) begin
        pick.b_idx    <= beat.idx;
        pick.b_weight <= beat.weight;
        b_ok          <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/huffman_code_builder_unit.sv -----
// Top level of the Huffman code builder: sequencer, node store, scan unit.
// Depends on hcb_pkg, hcb_node_ram and hcb_min_scan.
//
//  channel | signals                      | dir | payload
//  leaf    | leaf_valid, leaf_ready, leaf | in  | leaf_beat_t (weight, last_leaf)
//  code    | code_valid, code_ready, code | out | code_beat_t (one per leaf)
//
// A non-final leaf is only stored. The final leaf starts the build: each of
// the n-1 merges scans all live nodes through the single read port of the node
// store, then each leaf walks to the root at one level a cycle and ends in one
// output beat. No clearing pass after reset. leaf_ready is high only while
// collecting leaves; a stalled code beat holds.
module huffman_code_builder_unit
  import hcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       leaf_valid,
  output logic       leaf_ready,
  input  leaf_beat_t leaf,
  output logic       code_valid,
  input  logic       code_ready,
  output code_beat_t code
);

  hcb_state_t state, state_next;

  logic [NODE_W-1:0] leaf_count, leaf_count_next;
  logic              ovf, ovf_next;
  logic [NODE_W-1:0] top_node, top_node_next;
  logic [NODE_W-1:0] scan_addr, scan_addr_next;
  logic [NODE_W-1:0] leaf_sel, leaf_sel_next;
  logic [LEN_W-1:0]  depth, depth_next;
  logic [CODE_W-1:0] code_acc, code_acc_next;
  code_beat_t        code_next;
  logic              rd_pending;
  logic [NODE_W-1:0] rd_idx;

  logic              we;
  logic [NODE_W-1:0] waddr, raddr;
  node_word_t        wdata, rdata;
  scan_beat_t        scan_beat;
  scan_pick_t        pick;
  logic [NODE_W-1:0] n_new;

  hcb_node_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Feed read data into the compare unit in the cycle after each scan read
  always_comb begin
    scan_beat.clear  = (state == S_SCAN) && (scan_addr == NODE_W'(1));
    scan_beat.valid  = rd_pending;
    scan_beat.idx    = rd_idx;
    scan_beat.weight = rdata.weight;
    scan_beat.orphan = (rdata.parent == '0);
  end

  hcb_min_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .beat (scan_beat),
    .pick (pick)
  );

  // State register and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      leaf_count <= '0;
      ovf        <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      leaf_count <= leaf_count_next;
      ovf        <= ovf_next;
      rd_pending <= (state == S_SCAN);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    top_node  <= top_node_next;
    scan_addr <= scan_addr_next;
    leaf_sel  <= leaf_sel_next;
    depth     <= depth_next;
    code_acc  <= code_acc_next;
    code      <= code_next;
    rd_idx    <= scan_addr;
  end

  assign leaf_ready = (state == S_IDLE);
  assign code_valid = (state == S_OUT);

  // Next state, store accesses and register updates
  always_comb begin
    state_next      = state;
    leaf_count_next = leaf_count;
    ovf_next        = ovf;
    top_node_next   = top_node;
    scan_addr_next  = scan_addr;
    leaf_sel_next   = leaf_sel;
    depth_next      = depth;
    code_acc_next   = code_acc;
    code_next       = code;
    we              = 1'b0;
    waddr           = '0;
    wdata           = '0;
    raddr           = scan_addr;
    n_new           = leaf_count;

    unique case (state)
      S_IDLE: begin
        if (leaf_valid) begin
          if (leaf_count < NODE_W'(MAX_LEAVES)) begin
            we              = 1'b1;
            waddr           = leaf_count + NODE_W'(1);
            wdata.weight    = SUM_W'(leaf.weight);
            n_new           = leaf_count + NODE_W'(1);
            leaf_count_next = n_new;
          end else begin
            ovf_next = 1'b1;
          end
          if (leaf.last_leaf) begin
            if (n_new == NODE_W'(1)) begin
              leaf_sel_next = NODE_W'(1);
              state_next    = S_WALK_START;
            end else begin
              top_node_next  = n_new;
              scan_addr_next = NODE_W'(1);
              state_next     = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_addr == top_node) begin
          state_next = S_DRAIN;
        end else begin
          scan_addr_next = scan_addr + NODE_W'(1);
        end
      end
      S_DRAIN: begin
        state_next = S_WR_NEW;
      end
      // Create the merged node, then link both children to it
      S_WR_NEW: begin
        we           = 1'b1;
        waddr        = top_node + NODE_W'(1);
        wdata.weight = pick.a_weight + pick.b_weight;
        state_next   = S_WR_LO;
      end
      S_WR_LO: begin
        we           = 1'b1;
        waddr        = pick.a_idx;
        wdata.parent = top_node + NODE_W'(1);
        wdata.weight = pick.a_weight;
        state_next   = S_WR_HI;
      end
      S_WR_HI: begin
        we            = 1'b1;
        waddr         = pick.b_idx;
        wdata.right   = 1'b1;
        wdata.parent  = top_node + NODE_W'(1);
        wdata.weight  = pick.b_weight;
        top_node_next = top_node + NODE_W'(1);
        if (({1'b0, top_node} + 7'd2) == {leaf_count, 1'b0}) begin
          leaf_sel_next = NODE_W'(1);
          state_next    = S_WALK_START;
        end else begin
          scan_addr_next = NODE_W'(1);
          state_next     = S_SCAN;
        end
      end
      S_WALK_START: begin
        raddr         = leaf_sel;
        depth_next    = '0;
        code_acc_next = '0;
        state_next    = S_WALK;
      end
      // Climb one level per cycle; the read of the parent is issued at once
      S_WALK: begin
        if (rdata.parent != '0 && depth != LEN_W'(CODE_W)) begin
          code_acc_next = code_acc | (CODE_W'(rdata.right) << depth);
          depth_next    = depth + LEN_W'(1);
          raddr         = rdata.parent;
        end else begin
          code_next.leaf_index  = 5'(leaf_sel - NODE_W'(1));
          code_next.code_bits   = code_acc;
          code_next.code_length = depth;
          code_next.last_code   = (leaf_sel == leaf_count);
          code_next.overflowed  = ovf;
          state_next            = S_OUT;
        end
      end
      S_OUT: begin
        if (code_ready) begin
          if (leaf_sel == leaf_count) begin
            leaf_count_next = '0;
            ovf_next        = 1'b0;
            state_next      = S_IDLE;
          end else begin
            leaf_sel_next = leaf_sel + NODE_W'(1);
            state_next    = S_WALK_START;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/hcb_checker.sv -----
// Port-level checks for huffman_code_builder_unit, bound to the top level.
// Depends on hcb_pkg.
module hcb_checker
  import hcb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       leaf_valid,
  input logic       leaf_ready,
  input leaf_beat_t leaf,
  input logic       code_valid,
  input logic       code_ready,
  input code_beat_t code
);

  // A stalled code beat holds
  a_code_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_ready |=> code_valid && $stable(code))
    else $error("code beat changed while stalled");

  // No leaf is taken while codes are being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> !leaf_ready)
    else $error("leaf_ready high with a pending code beat");

  // Code has no bits above its length
  a_code_clean: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> ((code.code_bits >> code.code_length) == '0))
    else $error("code bits set above code length");

  // Delivering the final code reopens the leaf channel
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_ready && code.last_code |=> leaf_ready && !code_valid)
    else $error("leaf channel not reopened after final code");

  // Reset leaves the block collecting leaves
  a_reset_ready: assert property (@(posedge clk)
    rst |=> leaf_ready && !code_valid)
    else $error("block not ready after reset");

endmodule

bind huffman_code_builder_unit hcb_checker u_hcb_checker (
  .clk        (clk),
  .rst        (rst),
  .leaf_valid (leaf_valid),
  .leaf_ready (leaf_ready),
  .leaf       (leaf),
  .code_valid (code_valid),
  .code_ready (code_ready),
  .code       (code)
);

// ----- tb/sv/huffman_code_builder_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for huffman_code_builder_unit: feeds leaf-weight batches,
// predicts the Huffman code of every leaf and checks each code beat in order.
// Depends on hcb_pkg and the huffman_code_builder_unit RTL.
module huffman_code_builder_unit_tb
  import hcb_pkg::*;
();

  typedef enum int {
    STYLE_RANDOM,
    STYLE_FIB,
    STYLE_PEAK
  } batch_style_t;

  typedef struct packed {
    leaf_beat_t beat;
    logic       drain_first;
  } pending_leaf_t;

  localparam int TAIL_ITEMS = 30;
  localparam int LONG_HOLD  = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       leaf_valid = 1'b0;
  logic       leaf_ready;
  leaf_beat_t leaf = '0;
  logic       code_valid;
  logic       code_ready = 1'b0;
  code_beat_t code;

  huffman_code_builder_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .leaf_valid (leaf_valid),
    .leaf_ready (leaf_ready),
    .leaf       (leaf),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code       (code)
  );

  always #1 clk = ~clk;

  // Predicted tree state; node 0 means none
  logic [SUM_W-1:0]  tree_weight [0:NODE_SLOTS-1];
  logic [NODE_W-1:0] tree_parent [0:NODE_SLOTS-1];
  logic [NODE_W-1:0] tree_left   [0:NODE_SLOTS-1];
  logic [NODE_W-1:0] tree_right  [0:NODE_SLOTS-1];
  int unsigned       leaves_held  = 0;
  bit                dropped_leaf = 1'b0;

  pending_leaf_t leaves_to_send [$];
  code_beat_t    codes_due [$];
  int            mismatches = 0;

  int send_gap  = 0;
  int send_calm = 0;
  int recv_gap  = 0;
  int recv_calm = 0;
  int hold_left = 0;
  int codes_taken = 0;
  bit long_hold_done = 1'b0;

  initial begin
    for (int i = 0; i < NODE_SLOTS; i++) begin
      tree_weight[i] = '0;
      tree_parent[i] = '0;
      tree_left[i]   = '0;
      tree_right[i]  = '0;
    end
  end

  // Find the two lightest parentless nodes in 1..top; ties go to the lower index
  task automatic find_lightest(input int top, output int lo, output int hi);
    int a;
    int b;
    a = 0;
    b = 0;
    for (int i = 1; i <= top; i++) begin
      if (tree_parent[i] == 0) begin
        if (a == 0 || tree_weight[i] < tree_weight[a]) begin
          b = a;
          a = i;
        end else if (b == 0 || tree_weight[i] < tree_weight[b]) begin
          b = i;
        end
      end
    end
    lo = a;
    hi = b;
  endtask

  // Store one leaf; on the final leaf build the tree and queue one code per leaf
  task automatic absorb_leaf(input leaf_beat_t b);
    int n;
    int lo;
    int hi;
    int cur;
    int up;
    int depth;
    logic [CODE_W-1:0] path;
    code_beat_t want;
    if (leaves_held < MAX_LEAVES) begin
      leaves_held++;
      tree_weight[leaves_held] = SUM_W'(b.weight);
      tree_parent[leaves_held] = '0;
      tree_left[leaves_held]   = '0;
      tree_right[leaves_held]  = '0;
    end else begin
      dropped_leaf = 1'b1;
    end
    if (b.last_leaf) begin
      n = leaves_held;
      for (int i = n + 1; i < NODE_SLOTS; i++) begin
        tree_parent[i] = '0;
        tree_left[i]   = '0;
        tree_right[i]  = '0;
      end
      // Merge until one root is left
      for (int i = n + 1; i + 1 <= 2 * n; i++) begin
        find_lightest(i - 1, lo, hi);
        tree_weight[i] = tree_weight[lo] + tree_weight[hi];
        tree_parent[lo] = NODE_W'(i);
        tree_parent[hi] = NODE_W'(i);
        tree_left[i]    = NODE_W'(lo);
        tree_right[i]   = NODE_W'(hi);
      end
      // Walk each leaf to the root; the first step up is the last code bit
      for (int i = 1; i <= n; i++) begin
        path  = '0;
        depth = 0;
        cur   = i;
        up    = tree_parent[i];
        while (up != 0 && depth < CODE_W) begin
          if (tree_right[up] == cur) path[depth] = 1'b1;
          depth++;
          cur = up;
          up  = tree_parent[cur];
        end
        want.leaf_index  = 5'(i - 1);
        want.code_bits   = path;
        want.code_length = LEN_W'(depth);
        want.last_code   = (i == n);
        want.overflowed  = dropped_leaf;
        codes_due.push_back(want);
      end
      for (int i = 0; i < NODE_SLOTS; i++) begin
        tree_parent[i] = '0;
        tree_left[i]   = '0;
        tree_right[i]  = '0;
      end
      leaves_held  = 0;
      dropped_leaf = 1'b0;
    end
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return WEIGHT_W'($urandom_range(0, 3));
      5:       return WEIGHT_W'(1) << $urandom_range(0, WEIGHT_W - 1);
      default: return WEIGHT_W'($urandom());
    endcase
  endfunction

  task automatic queue_leaf(input logic [WEIGHT_W-1:0] w, input logic fin,
                            input logic drain);
    pending_leaf_t item;
    item.beat.weight    = w;
    item.beat.last_leaf = fin;
    item.drain_first    = drain;
    leaves_to_send.push_back(item);
  endtask

  task automatic queue_batch(input int size, input batch_style_t style, input logic drain);
    logic [WEIGHT_W-1:0] w;
    int fa;
    int fb;
    int fc;
    fa = 1;
    fb = 1;
    for (int i = 0; i < size; i++) begin
      case (style)
        STYLE_FIB: begin
          w  = WEIGHT_W'(fa);
          fc = fa + fb;
          fa = fb;
          fb = fc;
        end
        STYLE_PEAK: w = '1;
        default:    w = pick_weight();
      endcase
      queue_leaf(w, i == size - 1, drain && i == 0);
    end
  endtask

  // Fill the stimulus, release reset, then wait for the last code
  initial begin
    int batches;
    int total;
    // Directed: lone leaves at both extremes, a pair, ties, zero weights, a chain
    queue_leaf(16'h0000, 1'b1, 1'b0);
    queue_leaf(16'hFFFF, 1'b1, 1'b0);
    queue_leaf(16'hFFFF, 1'b0, 1'b0);
    queue_leaf(16'h0000, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) queue_leaf(16'd7, i == 3, 1'b0);
    queue_leaf(16'h0000, 1'b0, 1'b0);
    queue_leaf(16'h0000, 1'b0, 1'b0);
    queue_leaf(16'hFFFF, 1'b1, 1'b0);
    for (int i = 0; i < 5; i++) queue_leaf(16'd1 << i, i == 4, 1'b0);

    // Random batches, mostly small, with a deep tree, a full one and an overflow
    batches = 0;
    total   = leaves_to_send.size();
    while (total < 160 || batches < 10) begin
      case (batches)
        3:       queue_batch(18, STYLE_FIB, 1'b0);
        6:       queue_batch(MAX_LEAVES, STYLE_PEAK, 1'b0);
        9:       queue_batch(MAX_LEAVES + 1, STYLE_RANDOM, 1'b0);
        default: begin
          if ($urandom_range(0, 5) == 0) queue_batch($urandom_range(9, 16), STYLE_RANDOM,
                                                     batches == 0);
          else queue_batch($urandom_range(1, 8), STYLE_RANDOM, batches == 0);
        end
      endcase
      batches++;
      total = leaves_to_send.size();
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (leaves_to_send.size() != 0 || leaf_valid) @(posedge clk);
    while (codes_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && codes_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // Leaf driver: hold the beat until taken, then offer the next one or idle
  always @(posedge clk) begin : drive_leaves
    pending_leaf_t item;
    bit offer;
    int roll;
    if (rst) begin
      leaf_valid <= 1'b0;
      leaf       <= '0;
    end else if (!leaf_valid || leaf_ready) begin
      if (leaf_valid) absorb_leaf(leaf);
      offer = 1'b0;
      if (send_calm > 0) send_calm--;
      if (send_gap > 0) begin
        send_gap--;
      end else if (leaves_to_send.size() != 0 &&
                   !(leaves_to_send[0].drain_first && codes_due.size() != 0)) begin
        roll = $urandom_range(0, 9);
        if (leaves_to_send.size() > TAIL_ITEMS && send_calm == 0 && roll < 2) begin
          // This cycle is the first idle one of the burst
          send_gap = $urandom_range(0, 16);
        end else begin
          if (leaves_to_send.size() > TAIL_ITEMS && send_calm == 0 && roll == 2)
            send_calm = $urandom_range(20, 80);
          item  = leaves_to_send.pop_front();
          leaf  <= item.beat;
          offer = 1'b1;
        end
      end
      leaf_valid <= offer;
    end
  end

  // Code receiver: random stalls, one long hold-off, none near the end
  always @(posedge clk) begin : accept_codes
    int roll;
    if (rst) begin
      code_ready <= 1'b0;
    end else begin
      if (code_valid && code_ready) codes_taken++;
      if (!long_hold_done && codes_taken >= 40) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (recv_calm > 0) recv_calm--;
      if (hold_left > 0) begin
        hold_left--;
        code_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        code_ready <= 1'b0;
      end else begin
        roll = $urandom_range(0, 9);
        if (leaves_to_send.size() > TAIL_ITEMS && recv_calm == 0 && roll < 2) begin
          recv_gap = $urandom_range(0, 16);
          code_ready <= 1'b0;
        end else begin
          if (leaves_to_send.size() > TAIL_ITEMS && recv_calm == 0 && roll == 2)
            recv_calm = $urandom_range(20, 80);
          code_ready <= 1'b1;
        end
      end
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: code %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each taken code beat with the oldest prediction
  always @(posedge clk) begin : check_codes
    code_beat_t want;
    if (!rst && code_valid && code_ready) begin
      if (codes_due.size() == 0) begin
        $display("%0t: unexpected code beat: expected none, actual leaf %0d code %0h len %0d",
                 $time, code.leaf_index, code.code_bits, code.code_length);
        mismatches++;
      end else begin
        want = codes_due.pop_front();
        check_field("leaf_index", want.leaf_index, code.leaf_index);
        check_field("code_bits", want.code_bits, code.code_bits);
        check_field("code_length", want.code_length, code.code_length);
        check_field("last_code", want.last_code, code.last_code);
        check_field("overflowed", want.overflowed, code.overflowed);
      end
    end
  end

endmodule

// ----- huffman_code_builder_unit.f -----
hdl/hcb_pkg.sv
hdl/hcb_node_ram.sv
hdl/hcb_min_scan.sv
hdl/huffman_code_builder_unit.sv
hdl/hcb_checker.sv
tb/sv/huffman_code_builder_unit_tb.sv
